// File: hw/rtl/tilt_angle_step_detector_defines.svh
// ----------------------------------------------------------------------------
// tilt angle step detector assertion macros
// Shared concurrent assertion helpers, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef TILT_ANGLE_STEP_DETECTOR_DEFINES_SVH
`define TILT_ANGLE_STEP_DETECTOR_DEFINES_SVH

// same-cycle implication
`define TASD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tasd assertion failed");

// next-cycle implication
`define TASD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tasd assertion failed");

`endif

// File: hw/rtl/tasd_pkg.sv
// ----------------------------------------------------------------------------
// tasd_pkg
// Types and constants for the tilt angle step detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tasd_pkg;

  localparam int AngleW = 16;
  localparam int CountW = 32;
  localparam int CfgW   = 16;

  // filter restart value, 90 degrees in Q8.8
  localparam logic [AngleW-1:0] FiltReset = 16'd23040;

  // register reset values
  localparam logic [CfgW-1:0] StartThrReset  = 16'd17920;
  localparam logic [CfgW-1:0] ReturnThrReset = 16'd18432;
  localparam logic [CfgW-1:0] MinIntReset    = 16'd8;
  localparam logic [CfgW-1:0] MaxActReset    = 16'd64;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_START_THR    = 2'd0,
    REG_RETURN_THR   = 2'd1,
    REG_MIN_INTERVAL = 2'd2,
    REG_MAX_ACTIVE   = 2'd3
  } cfg_index_t;

endpackage

`default_nettype wire

// File: hw/rtl/tilt_angle_step_detector.sv
// An input transfer loads the input register; the result register loads from it
// when the output can advance. Throughput: one item per cycle while out_ready
// holds; the input register refills while a result waits, and the detector
// state updates in the single pass between the two.
// Reset (rst, synchronous): registers return to their defaults, the detector
// restarts at 90 degrees with zero counts, and both stages empty.
// ----------------------------------------------------------------------------
// tilt_angle_step_detector
// Smooths tilt-angle samples and counts steps with a two-state detector.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tilt_angle_step_detector_defines.svh"

module tilt_angle_step_detector
  import tasd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CfgW-1:0]      cfg_data,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire opcode_t              opcode,
  input  wire logic [AngleW-1:0]    angle,
  // output channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CountW-1:0]         total_steps,
  output logic                      step_seen,
  output logic [AngleW-1:0]         smoothed_angle,
  output logic                      armed
);

  // configuration registers
  logic [CfgW-1:0] start_thr;
  logic [CfgW-1:0] return_thr;
  logic [CfgW-1:0] min_interval;
  logic [CfgW-1:0] max_active;

  // input stage
  logic              s1_valid;
  opcode_t           s1_opcode;
  logic [AngleW-1:0] s1_angle;

  // detector state
  logic [AngleW-1:0] filtered_angle;
  logic [CountW-1:0] sample_counter;
  logic [CountW-1:0] last_step_stamp;
  logic [CountW-1:0] arm_stamp;
  logic              armed_flag;
  logic [CountW-1:0] step_total;

  logic [AngleW-1:0] filtered_angle_next;
  logic [CountW-1:0] sample_counter_next;
  logic [CountW-1:0] last_step_stamp_next;
  logic [CountW-1:0] arm_stamp_next;
  logic              armed_flag_next;
  logic [CountW-1:0] step_total_next;
  logic              seen_next;

  logic [AngleW+1:0] filt_sum;
  logic [CountW-1:0] since_step;
  logic [CountW-1:0] since_arm;
  logic              advance;
  logic              fire;

  // pipeline handshake
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign fire     = s1_valid && advance;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      start_thr    <= StartThrReset;
      return_thr   <= ReturnThrReset;
      min_interval <= MinIntReset;
      max_active   <= MaxActReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_THR:    start_thr    <= cfg_data;
        REG_RETURN_THR:   return_thr   <= cfg_data;
        REG_MIN_INTERVAL: min_interval <= cfg_data;
        REG_MAX_ACTIVE:   max_active   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode <= opcode;
      s1_angle  <= angle;
    end
  end

  // filter: (old + 3*new) / 4, truncated
  assign filt_sum = {2'b00, filtered_angle} + {1'b0, s1_angle, 1'b0} + {2'b00, s1_angle};

  assign sample_counter_next = (s1_opcode == OP_CLEAR) ? '0 : sample_counter + 1'b1;
  assign since_step = sample_counter_next - last_step_stamp;
  assign since_arm  = sample_counter_next - arm_stamp;

  // detector next state
  always_comb begin
    filtered_angle_next  = filt_sum[AngleW+1:2];
    last_step_stamp_next = last_step_stamp;
    arm_stamp_next       = arm_stamp;
    armed_flag_next      = armed_flag;
    step_total_next      = step_total;
    seen_next            = 1'b0;
    if (s1_opcode == OP_CLEAR) begin
      filtered_angle_next  = FiltReset;
      last_step_stamp_next = '0;
      arm_stamp_next       = '0;
      armed_flag_next      = 1'b0;
      step_total_next      = '0;
    end else if (!armed_flag) begin
      if ((filtered_angle_next < start_thr) &&
          (since_step >= {{(CountW-CfgW){1'b0}}, min_interval})) begin
        armed_flag_next = 1'b1;
        arm_stamp_next  = sample_counter_next;
      end
    end else begin
      // step and timeout together still count the step
      if (filtered_angle_next > return_thr) begin
        step_total_next      = step_total + 1'b1;
        last_step_stamp_next = sample_counter_next;
        armed_flag_next      = 1'b0;
        seen_next            = 1'b1;
      end
      if (since_arm > {{(CountW-CfgW){1'b0}}, max_active}) begin
        armed_flag_next = 1'b0;
      end
    end
  end

  // detector state update
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_angle  <= FiltReset;
      sample_counter  <= '0;
      last_step_stamp <= '0;
      arm_stamp       <= '0;
      armed_flag      <= 1'b0;
      step_total      <= '0;
    end else if (fire) begin
      filtered_angle  <= filtered_angle_next;
      sample_counter  <= sample_counter_next;
      last_step_stamp <= last_step_stamp_next;
      arm_stamp       <= arm_stamp_next;
      armed_flag      <= armed_flag_next;
      step_total      <= step_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      total_steps    <= step_total_next;
      step_seen      <= seen_next;
      smoothed_angle <= filtered_angle_next;
      armed          <= armed_flag_next;
    end
  end

  // checks
  `TASD_ASSERT_NOW(a_step_disarms, clk, rst, out_valid && step_seen, !armed)
  `TASD_ASSERT_NEXT(a_clear_result, clk, rst, fire && (s1_opcode == OP_CLEAR),
    (total_steps == '0) && (smoothed_angle == FiltReset) && !armed && !step_seen)
  `TASD_ASSERT_NEXT(a_armed_tracks, clk, rst, fire, armed == armed_flag)
  `TASD_ASSERT_NEXT(a_count_step, clk, rst, fire && (s1_opcode == OP_SAMPLE),
    total_steps == ($past(step_total) + {{(CountW-1){1'b0}}, step_seen}))

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives tilt-angle samples and clear commands into the step detector with
// random gaps on the input side and random back-pressure on the output side.
// A cycle-free copy of the filter and two-state detector, written here,
// predicts every result. Results are compared field by field as they
// transfer. Register settings change between drained phases: the reset
// values, both extremes, and random settings.
// ----------------------------------------------------------------------------

module testbench;
  import tasd_pkg::*;

  localparam int ClkHalf     = 6;
  localparam int Latency     = 2;
  localparam int StuckLimit  = 2000;
  localparam int RandomItems = 1050;

  typedef struct packed {
    opcode_t           op;
    logic [AngleW-1:0] angle;
  } sample_item_t;

  typedef struct packed {
    logic [CountW-1:0] steps;
    logic              seen;
    logic [AngleW-1:0] filt;
    logic              armed;
  } step_report_t;

  // clock, reset and block inputs, all known from time zero
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  cfg_index_t        cfg_idx   = REG_START_THR;
  logic [CfgW-1:0]   cfg_data  = '0;
  logic              in_valid  = 1'b0;
  opcode_t           in_op     = OP_SAMPLE;
  logic [AngleW-1:0] in_angle  = '0;
  logic              out_ready = 1'b0;

  logic              in_ready;
  logic              out_valid;
  logic [CountW-1:0] total_steps;
  logic              step_seen;
  logic [AngleW-1:0] smoothed_angle;
  logic              armed;

  // stimulus and expectation stores
  sample_item_t samples_todo[$];
  step_report_t reports_due[$];
  int           samples_sent  = 0;
  int           samples_taken = 0;
  int           queued_total  = 0;
  int           err_cnt       = 0;
  int           stuck_cycles  = 0;
  int           in_gap        = 0;
  int           out_gap       = 0;
  bit           in_idle_on    = 1'b0;
  bit           out_idle_on   = 1'b0;

  // register copies
  logic [CfgW-1:0] thr_start;
  logic [CfgW-1:0] thr_return;
  logic [CfgW-1:0] gap_min;
  logic [CfgW-1:0] active_max;

  // detector copy
  logic [AngleW-1:0] filt_q88;
  logic [CountW-1:0] sample_cnt;
  logic [CountW-1:0] last_step_at;
  logic [CountW-1:0] armed_at;
  logic              is_armed;
  logic [CountW-1:0] steps_total;

  tilt_angle_step_detector dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_idx),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (in_op),
    .angle          (in_angle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .total_steps    (total_steps),
    .step_seen      (step_seen),
    .smoothed_angle (smoothed_angle),
    .armed          (armed)
  );

  always #ClkHalf clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_len(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_detector();
    filt_q88     = FiltReset;
    sample_cnt   = '0;
    last_step_at = '0;
    armed_at     = '0;
    is_armed     = 1'b0;
    steps_total  = '0;
  endtask

  // one sample through the filter and detector, result queued
  task automatic track_detector(input opcode_t op, input logic [AngleW-1:0] a);
    logic [AngleW+1:0] sum;
    logic [CountW-1:0] since_step;
    logic [CountW-1:0] since_arm;
    step_report_t      rep;
    rep.seen = 1'b0;
    if (op == OP_CLEAR) begin
      clear_detector();
    end else begin
      sample_cnt = sample_cnt + 1'b1;
      sum        = {2'b00, filt_q88} + 18'(a) * 18'd3;
      filt_q88   = sum[AngleW+1:2];
      since_step = sample_cnt - last_step_at;
      since_arm  = sample_cnt - armed_at;
      if (!is_armed) begin
        if (filt_q88 < thr_start && since_step >= CountW'(gap_min)) begin
          is_armed = 1'b1;
          armed_at = sample_cnt;
        end
      end else begin
        if (filt_q88 > thr_return) begin
          steps_total  = steps_total + 1'b1;
          last_step_at = sample_cnt;
          is_armed     = 1'b0;
          rep.seen     = 1'b1;
        end
        // timeout still applies after a step on the same sample
        if (since_arm > CountW'(active_max)) is_armed = 1'b0;
      end
    end
    rep.steps = steps_total;
    rep.filt  = filt_q88;
    rep.armed = is_armed;
    reports_due.push_back(rep);
  endtask

  task automatic flag_mismatch(input string what, input logic [CountW-1:0] got,
                               input logic [CountW-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // input driver: hold until transfer, then gap, then next queued sample
  always @(negedge clk) begin
    sample_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && samples_sent != samples_taken) begin
      // item still waiting for its transfer
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap   <= in_gap - 1;
    end else if (samples_todo.size() > 0) begin
      it           = samples_todo.pop_front();
      in_valid     <= 1'b1;
      in_op        <= it.op;
      in_angle     <= it.angle;
      samples_sent <= samples_sent + 1;
      in_gap       <= idle_len(in_idle_on);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap   <= out_gap - 1;
    end else begin
      out_ready <= 1'b1;
      out_gap   <= idle_len(out_idle_on);
    end
  end

  // monitor: check result transfers, predict on input transfers
  always @(posedge clk) begin
    step_report_t due;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          flag_mismatch("result with none expected", total_steps, '0);
        end else begin
          due = reports_due.pop_front();
          if (total_steps !== due.steps)
            flag_mismatch("total_steps", total_steps, due.steps);
          if (step_seen !== due.seen)
            flag_mismatch("step_seen", CountW'(step_seen), CountW'(due.seen));
          if (smoothed_angle !== due.filt)
            flag_mismatch("smoothed_angle", CountW'(smoothed_angle), CountW'(due.filt));
          if (armed !== due.armed)
            flag_mismatch("armed", CountW'(armed), CountW'(due.armed));
        end
      end
      if (in_valid && in_ready) begin
        samples_taken <= samples_taken + 1;
        track_detector(in_op, in_angle);
      end
    end
  end

  // watchdog: no transfer for too long while work is outstanding
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (samples_todo.size() == 0 && !in_valid && reports_due.size() == 0)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic push_sample(input opcode_t op, input logic [AngleW-1:0] a);
    sample_item_t it;
    it.op    = op;
    it.angle = a;
    samples_todo.push_back(it);
    queued_total++;
  endtask

  task automatic wait_drained();
    while (samples_todo.size() != 0 || samples_sent != samples_taken ||
           reports_due.size() != 0)
      @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgW-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    case (idx)
      REG_START_THR:    thr_start  = v;
      REG_RETURN_THR:   thr_return = v;
      REG_MIN_INTERVAL: gap_min    = v;
      REG_MAX_ACTIVE:   active_max = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [CfgW-1:0] s, input logic [CfgW-1:0] r,
                           input logic [CfgW-1:0] mi, input logic [CfgW-1:0] ma);
    write_reg(REG_START_THR, s);
    write_reg(REG_RETURN_THR, r);
    write_reg(REG_MIN_INTERVAL, mi);
    write_reg(REG_MAX_ACTIVE, ma);
  endtask

  // angle somewhere below the arming threshold
  function automatic logic [AngleW-1:0] lo_level();
    int unsigned span;
    if (thr_start == 0) return '0;
    span = (thr_start > 4000) ? 4000 : thr_start;
    return thr_start - AngleW'($urandom_range(1, span));
  endfunction

  // angle somewhere above the return threshold
  function automatic logic [AngleW-1:0] hi_level();
    int unsigned span;
    if (thr_return == 16'hFFFF) return 16'hFFFF;
    span = 65535 - thr_return;
    if (span > 4000) span = 4000;
    return thr_return + AngleW'($urandom_range(1, span));
  endfunction

  // high dwell, dip below start, rise back above return
  task automatic queue_step_cycle();
    int n_hi;
    int n_lo;
    n_hi = $urandom_range(1, 4) + ((gap_min < 16) ? int'(gap_min) : 16);
    n_lo = $urandom_range(2, 6);
    repeat (n_hi) push_sample(OP_SAMPLE, hi_level());
    repeat (n_lo) push_sample(OP_SAMPLE, lo_level());
    repeat ($urandom_range(1, 2)) push_sample(OP_SAMPLE, hi_level());
  endtask

  task automatic pick_random_regs();
    int            r;
    logic [CfgW-1:0] s;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      write_all(16'd0, 16'd0, 16'd0, 16'd0);
    end else if (r == 1) begin
      write_all(16'd46080, 16'd46080, 16'hFFFF, 16'hFFFF);
    end else begin
      s = CfgW'($urandom_range(8000, 30000));
      write_all(s, s + CfgW'($urandom_range(0, 4000)), CfgW'($urandom_range(0, 12)),
                (r == 2) ? 16'hFFFF : CfgW'($urandom_range(0, 80)));
    end
  endtask

  initial begin
    int base;
    int target;
    int r;
    int n;
    thr_start  = StartThrReset;
    thr_return = ReturnThrReset;
    gap_min    = MinIntReset;
    active_max = MaxActReset;
    clear_detector();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: clear with angle ignored, arm after the minimum
    // interval, step on a 180-degree angle, filter past 180 degrees
    push_sample(OP_CLEAR, 16'hFFFF);
    repeat (8) push_sample(OP_SAMPLE, 16'd0);
    push_sample(OP_SAMPLE, 16'd46080);
    push_sample(OP_SAMPLE, 16'hFFFF);
    push_sample(OP_CLEAR, 16'h0000);
    wait_drained();

    // high extremes, no interval, instant timeout: step and timeout together
    write_all(16'd46080, 16'd46080, 16'd0, 16'd0);
    push_sample(OP_SAMPLE, 16'd0);
    push_sample(OP_SAMPLE, 16'hFFFF);
    push_sample(OP_SAMPLE, 16'd0);
    push_sample(OP_SAMPLE, 16'd0);
    push_sample(OP_SAMPLE, 16'hFFFF);
    push_sample(OP_CLEAR, 16'h5555);
    wait_drained();

    // low thresholds, largest interval and timeout: nothing can arm
    write_all(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    push_sample(OP_SAMPLE, 16'h8000);
    push_sample(OP_SAMPLE, 16'h5555);
    push_sample(OP_SAMPLE, 16'hAAAA);
    push_sample(OP_SAMPLE, 16'd0);

    // random phases, each starting from a drained block
    base = queued_total;
    while (queued_total - base < RandomItems) begin
      wait_drained();
      pick_random_regs();
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      target = queued_total + $urandom_range(80, 120);
      while (queued_total < target) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          queue_step_cycle();
        end else if (r < 80) begin
          repeat ($urandom_range(1, 5))
            push_sample(OP_SAMPLE, AngleW'($urandom_range(0, 65535)));
        end else if (r < 85) begin
          push_sample(OP_CLEAR, AngleW'($urandom_range(0, 65535)));
        end else if (r < 93) begin
          // dip held past the timeout, when that timeout is below 80
          n = (active_max < 80) ? int'(active_max) + $urandom_range(1, 8)
                                : $urandom_range(10, 90);
          repeat (n) push_sample(OP_SAMPLE, lo_level());
        end else begin
          // brief dip that may not reach the start threshold
          push_sample(OP_SAMPLE, lo_level());
          push_sample(OP_SAMPLE, hi_level());
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
